### hw/rtl/rta_pkg.sv
`timescale 1ns / 1ps

package rta_pkg;

  localparam int unsigned RULE_ENTRIES = 64;
  localparam logic [4:0]  START_STATE  = 5'd18;
  localparam logic [4:0]  END_MARK     = 5'd26;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHAR  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [5:0] rule_index;
    logic [4:0] rule_from_state;
    logic [7:0] rule_symbol;
    logic [4:0] rule_next_state;
    logic       rule_valid;
    logic [7:0] word_char;
    logic       word_last;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic       reached_end;
    logic [7:0] matched_chars;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] from_state;
    logic [7:0] symbol;
    logic [4:0] next_state;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic write;
    logic start;
    logic scan;
    logic resolve;
    logic hit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic at_end;
    logic match;
    logic scan_end;
    logic last;
    logic out_free;
  } sts_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRAP
  } ctrl_state_e;

endpackage

### hw/rtl/rule_table_automaton_acceptor_core.sv
`timescale 1ns / 1ps

// Programmable automaton acceptor. Rule beats write one entry of a RuleEntries-deep rule
// memory; each character beat scans that memory through its single read port, one entry
// per cycle in index order, and stops at the first valid rule whose state and symbol
// match. A character after the end marker is resolved as a miss without a scan. A result
// beat is produced only for the last character of a word and waits in an output register,
// so the next beat is taken while it is held. After reset the block sweeps every entry of
// the rule memory to invalid and stalls its input meanwhile.
module rule_table_automaton_acceptor_core #(
  parameter int unsigned RuleEntries = rta_pkg::RULE_ENTRIES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rta_pkg::in_t  in_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output rta_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_stall_i
);
  import rta_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  ctrl_state_e state;

  rta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_i.operation),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .state_o    (state)
  );

  rta_dp #(
    .RuleEntries (RuleEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  a_accept_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_o.accepted || out_o.reached_end))
    else $error("accepted word without reaching the end marker");

  a_accept_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.accepted) |-> (out_o.matched_chars != 8'd0))
    else $error("accepted word with no matched characters");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_valid_o)
    else $error("result beat lost after emit");

  a_no_resolve_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_CLEAR) |-> (!cmd.resolve && !cmd.write && !cmd.emit))
    else $error("datapath command issued during clearing pass");

endmodule

### hw/rtl/rta_ctrl.sv
`timescale 1ns / 1ps

module rta_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  input  rta_pkg::sts_t sts_i,
  output rta_pkg::cmd_t cmd_o,
  output logic          in_stall_o,
  output rta_pkg::ctrl_state_e state_o
);
  import rta_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && (in_op_i == OP_CHAR)) begin
          state_d = sts_i.at_end ? ST_WRAP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.match || sts_i.scan_end) state_d = ST_WRAP;
      end
      ST_WRAP: begin
        if (!sts_i.last || sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_op_i == OP_WRITE) begin
            cmd_o.write = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            // Once the end marker is reached no rule can match.
            cmd_o.resolve = sts_i.at_end;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.match) begin
          cmd_o.resolve = 1'b1;
          cmd_o.hit     = 1'b1;
        end else if (sts_i.scan_end) begin
          cmd_o.resolve = 1'b1;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_WRAP: begin
        cmd_o.emit = sts_i.last && sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign state_o = state_q;

endmodule

### hw/rtl/rta_dp.sv
`timescale 1ns / 1ps

module rta_dp #(
  parameter int unsigned RuleEntries = rta_pkg::RULE_ENTRIES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rta_pkg::in_t  in_i,
  input  rta_pkg::cmd_t cmd_i,
  output rta_pkg::sts_t sts_o,
  output rta_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_stall_i
);
  import rta_pkg::*;

  localparam int unsigned IdxW = (RuleEntries > 1) ? $clog2(RuleEntries) : 1;
  localparam logic [IdxW-1:0] LastAddr = IdxW'(RuleEntries - 1);

  entry_t mem [RuleEntries];

  logic [IdxW-1:0] addr_q, addr_d;
  entry_t          rdata_q;
  logic            rvalid_q;
  logic            rlast_q;
  logic [7:0]      char_q;
  logic            last_q;
  logic [4:0]      cur_q, cur_d;
  logic [7:0]      cnt_q, cnt_d;
  logic            failed_q, failed_d;
  logic            ended_q, ended_d;
  out_t            out_q;
  logic            out_valid_q, out_valid_d;

  logic            idx_ok;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_entry;
  logic            match;
  logic [4:0]      next_clamped;

  assign idx_ok  = {26'b0, in_i.rule_index} < 32'(RuleEntries);
  assign wr_addr = IdxW'({{IdxW{1'b0}}, in_i.rule_index});

  always_comb begin
    wr_entry.valid      = in_i.rule_valid;
    wr_entry.from_state = in_i.rule_from_state;
    wr_entry.symbol     = in_i.rule_symbol;
    wr_entry.next_state = in_i.rule_next_state;
  end

  // One write port shared by the clearing pass and rule loads; one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem[addr_q] <= '0;
    end else if (cmd_i.write && idx_ok) begin
      mem[wr_addr] <= wr_entry;
    end
    rdata_q <= mem[addr_q];
  end

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.start) begin
      addr_d = '0;
    end else if (cmd_i.clear || cmd_i.scan) begin
      addr_d = (addr_q == LastAddr) ? '0 : addr_q + 1'b1;
    end
  end

  assign match = rvalid_q && rdata_q.valid && (rdata_q.from_state == cur_q)
                 && (rdata_q.symbol == char_q);
  assign next_clamped = (rdata_q.next_state >= END_MARK) ? END_MARK : rdata_q.next_state;

  always_comb begin
    cur_d    = cur_q;
    cnt_d    = cnt_q;
    failed_d = failed_q;
    ended_d  = ended_q;
    if (cmd_i.resolve) begin
      if (cmd_i.hit) begin
        cur_d = next_clamped;
        cnt_d = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
        if (next_clamped == END_MARK) ended_d = 1'b1;
      end else begin
        failed_d = 1'b1;
      end
    end else if (cmd_i.emit) begin
      cur_d    = START_STATE;
      cnt_d    = '0;
      failed_d = 1'b0;
      ended_d  = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rvalid_q    <= 1'b0;
      cur_q       <= START_STATE;
      cnt_q       <= '0;
      failed_q    <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      addr_q      <= addr_d;
      rvalid_q    <= cmd_i.scan;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      failed_q    <= failed_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rlast_q <= (addr_q == LastAddr);
    if (cmd_i.start) begin
      char_q <= in_i.word_char;
      last_q <= in_i.word_last;
    end
    if (cmd_i.emit) begin
      out_q.accepted      <= !failed_q && (cur_q == END_MARK);
      out_q.reached_end   <= ended_q;
      out_q.matched_chars <= cnt_q;
    end
  end

  always_comb begin
    sts_o.clear_last = (addr_q == LastAddr);
    sts_o.at_end     = (cur_q == END_MARK);
    sts_o.match      = match;
    sts_o.scan_end   = rvalid_q && rlast_q;
    sts_o.last       = last_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

### bench/word_result_checker.sv
`timescale 1ns / 1ps

module word_result_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rta_pkg::in_t  in_i,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  rta_pkg::out_t out_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            words_o,
  output int            accepted_o
);
  import rta_pkg::*;

  entry_t     rules [RULE_ENTRIES];
  logic [4:0] walk_state;
  logic [7:0] hit_count;
  logic       missed;
  logic       end_reached;
  out_t       verdicts [$];
  out_t       want;

  // Moves the automaton copy by one input beat. The last character of a word
  // queues the verdict for that word and restarts the walk in state S.
  task automatic take_beat(input in_t b);
    logic found;
    out_t v;
    if (b.operation == OP_WRITE) begin
      rules[b.rule_index].valid      = b.rule_valid;
      rules[b.rule_index].from_state = b.rule_from_state;
      rules[b.rule_index].symbol     = b.rule_symbol;
      rules[b.rule_index].next_state = b.rule_next_state;
    end else begin
      found = 1'b0;
      if (walk_state < END_MARK) begin
        for (int k = 0; k < RULE_ENTRIES; k++) begin
          if (!found && rules[k].valid && rules[k].from_state == walk_state &&
              rules[k].symbol == b.word_char) begin
            found      = 1'b1;
            walk_state = (rules[k].next_state >= END_MARK) ? END_MARK
                                                            : rules[k].next_state;
          end
        end
      end
      if (found) begin
        if (hit_count != 8'd255) hit_count++;
        if (walk_state == END_MARK) end_reached = 1'b1;
      end else begin
        missed = 1'b1;
      end
      if (b.word_last) begin
        v.accepted      = !missed && walk_state == END_MARK;
        v.reached_end   = end_reached;
        v.matched_chars = hit_count;
        verdicts.insert(verdicts.size(), v);
        walk_state  = START_STATE;
        hit_count   = '0;
        missed      = 1'b0;
        end_reached = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RULE_ENTRIES; k++) rules[k] = '0;
      walk_state   = START_STATE;
      hit_count    = '0;
      missed       = 1'b0;
      end_reached  = 1'b0;
      verdicts.delete();
      fail_count_o = 0;
      pending_o    = 0;
      words_o      = 0;
      accepted_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdicts.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result beat with no word pending: accepted=%0b reached_end=%0b",
                     $realtime, out_i.accepted, out_i.reached_end,
                     " matched_chars=%0d", out_i.matched_chars);
        end else begin
          want = verdicts.pop_front();
          words_o++;
          if (out_i.accepted === 1'b1) accepted_o++;
          if (out_i.accepted !== want.accepted || out_i.reached_end !== want.reached_end ||
              out_i.matched_chars !== want.matched_chars) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: word %0d expected accepted=%0b reached_end=%0b matched=%0d,",
                       $realtime, words_o, want.accepted, want.reached_end,
                       want.matched_chars,
                       " got accepted=%0b reached_end=%0b matched=%0d",
                       out_i.accepted, out_i.reached_end, out_i.matched_chars);
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_beat(in_i);
      pending_o = verdicts.size();
    end
  end

endmodule

### bench/tb_rule_table_automaton_acceptor_core.sv
`timescale 1ns / 1ps

module tb_rule_table_automaton_acceptor_core;
  import rta_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BEATS   = 110;
  localparam int CALM_TAIL      = 30;
  localparam int LONG_WORD      = 260;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  in_t  in_beat   = '0;
  logic in_valid  = 1'b0;
  logic in_stall;
  out_t out_beat;
  logic out_valid;
  logic out_stall = 1'b0;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int beats_sent = 0;
  int fail_count;
  int pending;
  int words;
  int accepted_words;

  // What the stimulus has written into the rule store; used only to build
  // words that actually walk the current grammar.
  logic       tbl_valid [RULE_ENTRIES];
  logic [4:0] tbl_from  [RULE_ENTRIES];
  logic [7:0] tbl_sym   [RULE_ENTRIES];
  logic [4:0] tbl_next  [RULE_ENTRIES];

  always #5 clk = ~clk;

  rule_table_automaton_acceptor_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_beat),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .out_o      (out_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall)
  );

  word_result_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_beat),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .out_i       (out_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .words_o     (words),
    .accepted_o  (accepted_words)
  );

  initial begin : result_backpressure
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Returns right after the edge that takes the beat, so valid stays up for a
  // following beat unless a gap or a drain lowers it.
  task automatic send_beat(input in_t b);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_beat  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic in_t random_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_t)-1:0];
  endfunction

  function automatic logic [7:0] random_symbol();
    logic [7:0] alphabet [5] = '{8'h20, 8'h61, 8'h62, 8'h63, 8'h64};
    if ($urandom_range(0, 3) != 0) return alphabet[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_rule(input int idx, input int from, input int sym, input int nxt,
                           input bit live);
    in_t b;
    b = random_beat();
    b.operation       = OP_WRITE;
    b.rule_index      = 6'(idx);
    b.rule_from_state = 5'(from);
    b.rule_symbol     = 8'(sym);
    b.rule_next_state = 5'(nxt);
    b.rule_valid      = live;
    tbl_valid[idx] = live;
    tbl_from[idx]  = 5'(from);
    tbl_sym[idx]   = 8'(sym);
    tbl_next[idx]  = 5'(nxt);
    send_beat(b);
  endtask

  task automatic send_char(input logic [7:0] ch, input bit last);
    in_t b;
    b = random_beat();
    b.operation = OP_CHAR;
    b.word_char = ch;
    b.word_last = last;
    send_beat(b);
  endtask

  // Leaving states lean toward S and a few low letters, with some that can
  // never match; targets lean toward the end marker, including codes above it.
  task automatic send_random_rule();
    int from, nxt;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: from = START_STATE;
      4, 5, 6:    from = $urandom_range(0, 3);
      7:          from = $urandom_range(0, 25);
      default:    from = $urandom_range(26, 31);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: nxt = END_MARK;
      3:       nxt = $urandom_range(27, 31);
      4, 5:    nxt = START_STATE;
      6, 7, 8: nxt = $urandom_range(0, 3);
      default: nxt = $urandom_range(0, 25);
    endcase
    send_rule($urandom_range(0, RULE_ENTRIES - 1), from, random_symbol(), nxt,
              $urandom_range(0, 9) != 0);
  endtask

  function automatic int first_target(input int st, input logic [7:0] sym);
    for (int k = 0; k < RULE_ENTRIES; k++)
      if (tbl_valid[k] && tbl_from[k] == st && tbl_sym[k] == sym)
        return (tbl_next[k] >= END_MARK) ? END_MARK : tbl_next[k];
    return END_MARK;
  endfunction

  // Most words follow the grammar from S, some with one character broken, extra
  // characters past the end or the last one cut; the rest are plain noise.
  task automatic send_word();
    logic [7:0] word [$];
    int         cands [$];
    int         st, pick;
    if ($urandom_range(0, 9) < 7) begin
      st = START_STATE;
      while (st < END_MARK && word.size() < 12) begin
        cands.delete();
        for (int k = 0; k < RULE_ENTRIES; k++)
          if (tbl_valid[k] && tbl_from[k] == st) cands.insert(cands.size(), k);
        if (cands.size() == 0) break;
        pick = cands[$urandom_range(0, cands.size() - 1)];
        word.insert(word.size(), tbl_sym[pick]);
        st = first_target(st, tbl_sym[pick]);
      end
      case ($urandom_range(0, 9))
        0: if (word.size() > 0) word[$urandom_range(0, word.size() - 1)] = random_symbol();
        1: repeat ($urandom_range(1, 3)) word.insert(word.size(), random_symbol());
        2: if (word.size() > 1) void'(word.pop_back());
        default: ;
      endcase
      if (word.size() == 0) word.insert(word.size(), random_symbol());
    end else begin
      repeat ($urandom_range(1, 6)) word.insert(word.size(), random_symbol());
    end
    foreach (word[i]) begin
      if ($urandom_range(0, 19) == 0) send_random_rule();
      send_char(word[i], i == word.size() - 1);
    end
  endtask

  initial begin : stimulus
    int first_random;
    for (int k = 0; k < RULE_ENTRIES; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_from[k]  = '0;
      tbl_sym[k]   = '0;
      tbl_next[k]  = '0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Last entry, top byte, straight to the end marker.
    send_rule(RULE_ENTRIES - 1, START_STATE, 8'hFF, END_MARK, 1'b1);
    send_char(8'hFF, 1'b1);
    // S -0x00-> A -space-> a target code above the end marker.
    send_rule(0, START_STATE, 8'h00, 0, 1'b1);
    send_rule(1, 0, 8'h20, 31, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'h20, 1'b1);
    // A rule write in the middle of a word; its leaving state can never match.
    send_char(8'h00, 1'b0);
    send_rule(2, 31, 8'h41, 0, 1'b1);
    send_char(8'h20, 1'b1);
    // A character after the end marker is a miss.
    send_char(8'h00, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h41, 1'b1);
    // No rule for this character in S.
    send_char(8'h41, 1'b1);
    // Into Z, a state with no rules at all.
    send_rule(3, START_STATE, 8'h42, 25, 1'b1);
    send_char(8'h42, 1'b0);
    send_char(8'h43, 1'b1);
    // Lower index wins over a later rule for the same state and symbol.
    send_rule(4, START_STATE, 8'h00, END_MARK, 1'b1);
    send_char(8'h00, 1'b1);
    // Removing the lower entry lets the later one through.
    send_rule(0, START_STATE, 8'h00, 0, 1'b0);
    send_char(8'h00, 1'b1);
    drain();

    // A self loop on Y drives the match count into saturation.
    send_rule(5, START_STATE, 8'h7E, 24, 1'b1);
    send_rule(6, 24, 8'h7E, 24, 1'b1);
    send_rule(7, 24, 8'h0A, END_MARK, 1'b1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (LONG_WORD - 1) send_char(8'h7E, 1'b0);
    send_char(8'h0A, 1'b1);

    first_random = beats_sent;
    while (beats_sent - first_random < RANDOM_BEATS) begin
      if (beats_sent - first_random > RANDOM_BEATS - CALM_TAIL) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = $urandom_range(0, 2) != 0;
        rx_idle_on = $urandom_range(0, 2) != 0;
      end
      repeat ($urandom_range(1, 6)) send_random_rule();
      repeat ($urandom_range(2, 6)) send_word();
      if ($urandom_range(0, 4) == 0) drain();
    end
    drain();
    repeat (100) @(negedge clk);

    $display("Covered %0d beats and %0d words (%0d accepted): rule priority, end marker,",
             beats_sent, words, accepted_words);
    $display("misses, saturation and random grammars under idling on both channels.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### rule_table_automaton_acceptor_core.f
hw/rtl/rta_pkg.sv
hw/rtl/rta_ctrl.sv
hw/rtl/rta_dp.sv
hw/rtl/rule_table_automaton_acceptor_core.sv
bench/word_result_checker.sv
bench/tb_rule_table_automaton_acceptor_core.sv
